FILE: rtl/core/kfst_pkg.sv
// Shared types, command codes and default sizes for the keyed flag set table.
`timescale 1ns / 1ps

package kfst_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_BITS_DEF = 32;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_TEST  = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] item_key;
    logic [31:0] flag_mask;
  } cmd_word_t;

  typedef struct packed {
    logic       answer;
    logic [6:0] entry_count;
    logic       table_full;
  } rsp_word_t;

endpackage

FILE: rtl/core/keyed_flag_set_table.sv
// Top level of the keyed flag set table: sequencer, scan compare unit and entry store.
`timescale 1ns / 1ps

// Each command word scans every entry of the store in index order through its
// single read port, one entry a cycle. After the scan a tail state covers the
// read latency and an update state registers the result word; cmd_stall stays
// high until the sequencer is back in idle, where the next command is taken.
// After reset a clearing pass walks the store once before the first command is
// taken. A result word waits in an output register; the update of the next
// command holds until it has been taken.
module keyed_flag_set_table
  import kfst_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_word_t cmd_word,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_word_t rsp_word
);

  localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = 1 + KW + 32;
  localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_TAIL = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;

  logic [2:0]    state;
  logic [AW-1:0] ptr;
  logic [CW-1:0] used_count;
  logic [1:0]    cmd;
  logic [KW-1:0] key;
  logic [31:0]   mask;

  logic          scan_v;
  logic [AW-1:0] scan_idx;
  logic          hit;
  logic [AW-1:0] hit_idx;
  logic [31:0]   hit_flags;
  logic          free_found;
  logic [AW-1:0] free_idx;

  logic          we;
  logic [AW-1:0] waddr;
  logic [MW-1:0] wdata;
  logic [MW-1:0] rdata;

  logic          upd_go;
  logic [CW-1:0] cnt_next;
  logic          answer_next;
  logic          full_next;
  logic [31:0]   clr_flags;

  kfst_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(MW)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (state == ST_SCAN),
    .raddr(ptr),
    .rdata(rdata)
  );

  assign cmd_stall = (state != ST_IDLE);
  assign upd_go    = (state == ST_UPD) && (!rsp_valid || !rsp_stall);
  assign clr_flags = hit_flags & ~mask;

  // update decision
  always_comb begin
    we          = 1'b0;
    waddr       = hit_idx;
    wdata       = {1'b1, key, hit_flags | mask};
    cnt_next    = used_count;
    answer_next = 1'b0;
    full_next   = 1'b0;
    if (state == ST_CLR) begin
      we    = 1'b1;
      waddr = ptr;
      wdata = '0;
    end else if (upd_go) begin
      case (cmd)
        CMD_ADD: begin
          answer_next = (used_count == '0);
          if (hit) begin
            we = 1'b1;
          end else if (free_found) begin
            we       = 1'b1;
            waddr    = free_idx;
            wdata    = {1'b1, key, mask};
            cnt_next = used_count + 1'b1;
          end else begin
            full_next   = 1'b1;
            answer_next = 1'b0;
          end
        end
        CMD_CLEAR: begin
          if (hit) begin
            we    = 1'b1;
            wdata = {(clr_flags != '0), key, clr_flags};
            if (clr_flags == '0) begin
              cnt_next = used_count - 1'b1;
            end
          end
          answer_next = (cnt_next == '0);
        end
        CMD_TEST: begin
          answer_next = hit && ((hit_flags & mask) != '0);
        end
        default: begin
          answer_next = 1'b0;
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLR;
      ptr        <= '0;
      used_count <= '0;
      scan_v     <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      scan_v <= (state == ST_SCAN);
      if (upd_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_CLR: begin
          if (ptr == LAST) begin
            ptr   <= '0;
            state <= ST_IDLE;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        ST_IDLE: begin
          if (cmd_valid) begin
            ptr   <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (ptr == LAST) begin
            ptr   <= '0;
            state <= ST_TAIL;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        ST_TAIL: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (upd_go) begin
            used_count <= cnt_next;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // command capture, scan compare unit and result word register
  always_ff @(posedge clk) begin
    scan_idx <= ptr;
    if (state == ST_IDLE && cmd_valid) begin
      cmd        <= cmd_word.cmd;
      key        <= cmd_word.item_key[KW-1:0];
      mask       <= cmd_word.flag_mask;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (scan_v) begin
      if (rdata[MW-1] && rdata[MW-2 -: KW] == key && !hit) begin
        hit       <= 1'b1;
        hit_idx   <= scan_idx;
        hit_flags <= rdata[31:0];
      end
      if (!rdata[MW-1] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= scan_idx;
      end
    end
    if (upd_go) begin
      rsp_word.answer      <= answer_next;
      rsp_word.entry_count <= 7'(cnt_next);
      rsp_word.table_full  <= full_next;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_count_moves_on_update: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(used_count)) |-> $past(state) == ST_UPD)
    else $error("entry count changed outside update");

  a_rsp_from_update: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(rsp_valid)) |-> $past(state) == ST_UPD)
    else $error("result word raised outside update");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (upd_go && full_next) |-> (!answer_next && used_count == CW'(CAPACITY)))
    else $error("add rejected on a table with room");
`endif

endmodule

FILE: rtl/core/kfst_ram.sv
// Single-port-write, single-port-read entry store with registered read data.
`timescale 1ns / 1ps

module kfst_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 65
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
